[rtl/ptsb_pkg.sv]
package ptsb_pkg;

	localparam int SLOTS_DEFAULT = 16;
	localparam int MAX_RESULTS   = 16;
	localparam int QUEUE_DEPTH   = 2;

	localparam logic [1:0] OP_TICK       = 2'd0;
	localparam logic [1:0] OP_ADD        = 2'd1;
	localparam logic [1:0] OP_REMOVE     = 2'd2;
	localparam logic [1:0] OP_REMOVE_ALL = 2'd3;

	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_FULL      = 2'd1;
	localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_FIRE   = 1'b1;

	typedef enum logic [1:0] {
		JOB_TICK,
		JOB_ADD,
		JOB_REMOVE,
		JOB_REMOVE_ALL
	} job_op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_DONE
	} back_state_t;

	typedef struct packed {
		logic [1:0]  operation;
		logic [31:0] entry_id;
		logic [31:0] period_ticks;
	} command_t;

	typedef struct packed {
		logic        result_kind;
		logic [1:0]  status_code;
		logic [31:0] fired_id;
		logic        last_of_run;
	} result_t;

	typedef struct packed {
		job_op_t     op;
		logic [31:0] entry_id;
		logic [31:0] period_ticks;
	} job_t;

	typedef struct packed {
		logic valid;
		job_t job;
	} job_chan_t;

	typedef struct packed {
		logic [31:0] id;
		logic [31:0] period;
		logic [31:0] countdown;
	} slot_t;

endpackage

[rtl/periodic_timer_slot_bank.sv]
// Channel   Beat marked by          Payload
// command   start high, busy low    command (operation, entry_id, period_ticks)
// result    strobe high, one cycle  result (result_kind, status_code, fired_id, last_of_run)
//
// Commands enter a two-beat queue, so busy rises only when that queue is full.
// Tick, add and remove walk the whole slot ring once, one slot a cycle, with fires
// appearing during the walk and just after it.
// Remove all, and an add to a full bank, answer in the cycle after leaving the queue.
// Reset empties the bank; the receiver cannot stall, so results are never held back.
module periodic_timer_slot_bank import ptsb_pkg::*; #(
	parameter int SLOTS = SLOTS_DEFAULT
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  command_t command,
	output logic     strobe,
	output result_t  result
);

	job_chan_t head;
	logic      pop;

	ptsb_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.command (command),
		.head    (head),
		.pop     (pop)
	);

	ptsb_back #(
		.SLOTS (SLOTS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.strobe (strobe),
		.result (result)
	);

endmodule

[rtl/ptsb_front.sv]
module ptsb_front import ptsb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  command_t  command,
	output job_chan_t head,
	input  logic      pop
);

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	job_t           queue_q [QUEUE_DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  fill_q;
	logic           push;
	logic           take;
	job_t           decoded;

	always_comb begin
		decoded.entry_id     = command.entry_id;
		decoded.period_ticks = command.period_ticks;
		unique case (command.operation)
			OP_TICK:       decoded.op = JOB_TICK;
			OP_ADD:        decoded.op = JOB_ADD;
			OP_REMOVE:     decoded.op = JOB_REMOVE;
			OP_REMOVE_ALL: decoded.op = JOB_REMOVE_ALL;
			default:       decoded.op = JOB_TICK;
		endcase
	end

	assign busy       = (fill_q == CW'(QUEUE_DEPTH));
	assign push       = start && !busy;
	assign take       = pop && (fill_q != '0);
	assign head.valid = (fill_q != '0);
	assign head.job   = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= decoded;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (take) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !take) begin
				fill_q <= fill_q + 1'b1;
			end else if (take && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

[rtl/ptsb_back.sv]
module ptsb_back import ptsb_pkg::*; #(
	parameter int SLOTS = SLOTS_DEFAULT
) (
	input  logic      clk,
	input  logic      arst_n,
	input  job_chan_t head,
	output logic      pop,
	output logic      strobe,
	output result_t   result
);

	localparam int IW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNW = $clog2(SLOTS + 1);
	localparam int FW  = $clog2(MAX_RESULTS + 1);
	localparam int NXT = (SLOTS > 1) ? 1 : 0;

	back_state_t    state_q;
	back_state_t    state_d;
	job_t           job_q;
	logic [IW-1:0]  step_q;
	logic [CNW-1:0] count_q;
	logic           vld_q [SLOTS];
	slot_t          dat_q [SLOTS];
	logic           carry_vld_q;
	slot_t          carry_q;
	logic           hit_q;
	logic           pend_vld_q;
	logic [31:0]    pend_id_q;
	logic [FW-1:0]  fire_n_q;
	logic           strobe_q;
	result_t        result_q;

	logic           last_step;
	logic           push_vld;
	slot_t          push_dat;
	logic           fire_now;
	logic           take_carry;
	slot_t          new_slot;
	logic           full;

	assign pop       = (state_q == ST_IDLE) && head.valid;
	assign full      = (count_q == CNW'(SLOTS));
	assign last_step = (step_q == IW'(SLOTS - 1));
	assign strobe    = strobe_q;
	assign result    = result_q;

	assign new_slot.id        = job_q.entry_id;
	assign new_slot.period    = job_q.period_ticks;
	assign new_slot.countdown = job_q.period_ticks;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (pop && !(head.job.op == JOB_REMOVE_ALL) &&
					!(head.job.op == JOB_ADD && full)) begin
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				if (last_step) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		push_vld   = vld_q[0];
		push_dat   = dat_q[0];
		fire_now   = 1'b0;
		take_carry = 1'b0;
		case (job_q.op)
			JOB_TICK: begin
				if (vld_q[0]) begin
					if (dat_q[0].countdown == '0) begin
						push_dat.countdown = dat_q[0].period;
						fire_now = 1'b1;
					end else begin
						push_dat.countdown = dat_q[0].countdown - 1'b1;
					end
				end
			end
			JOB_ADD: begin
				if (hit_q) begin
					push_vld   = carry_vld_q;
					push_dat   = carry_q;
					take_carry = 1'b1;
				end else if (!vld_q[0] || dat_q[0].period > job_q.period_ticks) begin
					push_vld   = 1'b1;
					push_dat   = new_slot;
					take_carry = 1'b1;
				end
			end
			JOB_REMOVE: begin
				if (hit_q || (vld_q[0] && dat_q[0].id == job_q.entry_id)) begin
					push_vld = last_step ? 1'b0 : vld_q[NXT];
					push_dat = dat_q[NXT];
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && pop) begin
			job_q <= head.job;
		end
		if (state_q == ST_WALK) begin
			for (int k = 0; k < SLOTS - 1; k++) begin
				dat_q[k] <= dat_q[k + 1];
			end
			dat_q[SLOTS - 1] <= push_dat;
			if (take_carry) begin
				carry_q <= dat_q[0];
			end
			if (fire_now && fire_n_q < FW'(MAX_RESULTS)) begin
				pend_id_q <= dat_q[0].id;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < SLOTS; k++) begin
				vld_q[k] <= 1'b0;
			end
			count_q     <= '0;
			step_q      <= '0;
			carry_vld_q <= 1'b0;
			hit_q       <= 1'b0;
			pend_vld_q  <= 1'b0;
			fire_n_q    <= '0;
			strobe_q    <= 1'b0;
			result_q    <= '0;
		end else begin
			strobe_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					step_q      <= '0;
					hit_q       <= 1'b0;
					carry_vld_q <= 1'b0;
					pend_vld_q  <= 1'b0;
					fire_n_q    <= '0;
					if (pop && head.job.op == JOB_REMOVE_ALL) begin
						for (int k = 0; k < SLOTS; k++) begin
							vld_q[k] <= 1'b0;
						end
						count_q  <= '0;
						strobe_q <= 1'b1;
						result_q <= '{KIND_STATUS, STATUS_OK, 32'd0, 1'b1};
					end else if (pop && head.job.op == JOB_ADD && full) begin
						strobe_q <= 1'b1;
						result_q <= '{KIND_STATUS, STATUS_FULL, 32'd0, 1'b1};
					end
				end
				ST_WALK: begin
					step_q <= step_q + 1'b1;
					for (int k = 0; k < SLOTS - 1; k++) begin
						vld_q[k] <= vld_q[k + 1];
					end
					vld_q[SLOTS - 1] <= push_vld;
					if (take_carry) begin
						carry_vld_q <= vld_q[0];
						hit_q       <= 1'b1;
					end
					if (job_q.op == JOB_REMOVE && vld_q[0] && dat_q[0].id == job_q.entry_id) begin
						hit_q <= 1'b1;
					end
					if (fire_now && fire_n_q < FW'(MAX_RESULTS)) begin
						fire_n_q   <= fire_n_q + 1'b1;
						pend_vld_q <= 1'b1;
						if (pend_vld_q) begin
							strobe_q <= 1'b1;
							result_q <= '{KIND_FIRE, STATUS_OK, pend_id_q, 1'b0};
						end
					end
				end
				ST_DONE: begin
					case (job_q.op)
						JOB_TICK: begin
							if (pend_vld_q) begin
								strobe_q <= 1'b1;
								result_q <= '{KIND_FIRE, STATUS_OK, pend_id_q, 1'b1};
							end
						end
						JOB_ADD: begin
							count_q  <= count_q + 1'b1;
							strobe_q <= 1'b1;
							result_q <= '{KIND_STATUS, STATUS_OK, 32'd0, 1'b1};
						end
						JOB_REMOVE: begin
							strobe_q <= 1'b1;
							if (hit_q) begin
								count_q  <= count_q - 1'b1;
								result_q <= '{KIND_STATUS, STATUS_OK, 32'd0, 1'b1};
							end else begin
								result_q <= '{KIND_STATUS, STATUS_NOT_FOUND, 32'd0, 1'b1};
							end
						end
						default: begin
						end
					endcase
				end
				default: begin
				end
			endcase
		end
	end

endmodule

[test/periodic_timer_slot_bank_tb.sv]
module periodic_timer_slot_bank_tb;
	import ptsb_pkg::*;

	localparam int SLOTS        = SLOTS_DEFAULT;
	localparam int IDLE_LIMIT   = 4000;
	localparam int DRAIN_CYCLES = 3 * (SLOTS + 2);
	localparam int RANDOM_ITEMS = 236;

	logic     clk     = 1'b0;
	logic     arst_n  = 1'b0;
	logic     start   = 1'b0;
	logic     busy;
	command_t command = '0;
	logic     strobe;
	result_t  result;

	logic [31:0] bank_id        [SLOTS];
	logic [31:0] bank_period    [SLOTS];
	logic [31:0] bank_countdown [SLOTS];
	int          bank_count = 0;
	result_t     owed_results [$];
	int          fail_count = 0;
	bit          burst_mode = 1'b0;

	periodic_timer_slot_bank #(.SLOTS(SLOTS)) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.command (command),
		.strobe  (strobe),
		.result  (result)
	);

	always #1 clk = ~clk;

	function automatic void timer_bank_step(input command_t cmd);
		result_t res;
		result_t fires [$];
		int      pos;
		res = '{result_kind: KIND_STATUS, status_code: STATUS_OK, fired_id: 32'd0,
			last_of_run: 1'b1};
		if (cmd.operation == OP_TICK) begin
			for (int k = 0; k < bank_count; k++) begin
				if (bank_countdown[k] != 32'd0) begin
					bank_countdown[k] = bank_countdown[k] - 32'd1;
				end else begin
					bank_countdown[k] = bank_period[k];
					if (fires.size() < MAX_RESULTS) begin
						fires.push_back('{result_kind: KIND_FIRE, status_code: STATUS_OK,
							fired_id: bank_id[k], last_of_run: 1'b0});
					end
				end
			end
			if (fires.size() > 0) begin
				fires[fires.size() - 1].last_of_run = 1'b1;
			end
			foreach (fires[i]) owed_results.push_back(fires[i]);
		end else begin
			case (cmd.operation)
				OP_ADD: begin
					if (bank_count >= SLOTS) begin
						res.status_code = STATUS_FULL;
					end else begin
						pos = 0;
						while (pos < bank_count && bank_period[pos] <= cmd.period_ticks) pos++;
						for (int k = bank_count; k > pos; k--) begin
							bank_id[k]        = bank_id[k - 1];
							bank_period[k]    = bank_period[k - 1];
							bank_countdown[k] = bank_countdown[k - 1];
						end
						bank_id[pos]        = cmd.entry_id;
						bank_period[pos]    = cmd.period_ticks;
						bank_countdown[pos] = cmd.period_ticks;
						bank_count++;
					end
				end
				OP_REMOVE: begin
					pos = 0;
					while (pos < bank_count && bank_id[pos] != cmd.entry_id) pos++;
					if (pos >= bank_count) begin
						res.status_code = STATUS_NOT_FOUND;
					end else begin
						for (int k = pos; k + 1 < bank_count; k++) begin
							bank_id[k]        = bank_id[k + 1];
							bank_period[k]    = bank_period[k + 1];
							bank_countdown[k] = bank_countdown[k + 1];
						end
						bank_count--;
					end
				end
				default: begin
					bank_count = 0;
				end
			endcase
			owed_results.push_back(res);
		end
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (burst_mode || r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// A command beat is taken at an edge where start is high and busy is low.
	task automatic send_item(input logic [1:0] op, input logic [31:0] id,
		input logic [31:0] period);
		command_t cmd;
		int       gap;
		cmd.operation    = op;
		cmd.entry_id     = id;
		cmd.period_ticks = period;
		start   <= 1'b1;
		command <= cmd;
		@(posedge clk);
		while (busy) @(posedge clk);
		timer_bank_step(cmd);
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic test_empty_bank();
		send_item(OP_REMOVE_ALL, 32'd0, 32'd0);
		send_item(OP_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(OP_REMOVE, 32'd5, 32'd0);
		send_item(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(OP_ADD, 32'd0, 32'd0);
		send_item(OP_ADD, 32'd1, 32'd0);
		send_item(OP_TICK, 32'd0, 32'd0);
		send_item(OP_REMOVE, 32'hFFFF_FFFF, 32'd0);
	endtask

	task automatic test_full_bank();
		for (int k = 0; bank_count < SLOTS; k++) begin
			send_item(OP_ADD, (k % 5 == 3) ? 32'd3 : 32'h5A00_0000 + k, 32'd0);
		end
		send_item(OP_ADD, 32'h0000_BEEF, 32'd0);
		send_item(OP_TICK, 32'd0, 32'd0);
		send_item(OP_REMOVE, 32'd3, 32'd0);
	endtask

	task automatic test_random_traffic();
		int          add_weight;
		int          pick;
		int          r;
		logic [31:0] id;
		logic [31:0] period;
		add_weight = 30;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 40 == 0) begin
				burst_mode = ($urandom_range(0, 3) == 0);
				add_weight = $urandom_range(20, 45);
			end
			id = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 7);
			r = $urandom_range(0, 99);
			if (r < 70) period = $urandom_range(0, 4);
			else if (r < 92) period = $urandom_range(5, 24);
			else period = $urandom;
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				send_item(OP_TICK, $urandom, $urandom);
			end else if (pick < 45 + add_weight) begin
				send_item(OP_ADD, id, period);
			end else if (pick < 96) begin
				if (bank_count > 0 && $urandom_range(0, 9) < 7) begin
					id = bank_id[$urandom_range(0, bank_count - 1)];
				end
				send_item(OP_REMOVE, id, $urandom);
			end else begin
				send_item(OP_REMOVE_ALL, $urandom, $urandom);
			end
		end
		burst_mode = 1'b0;
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n && strobe) begin
			if (owed_results.size() == 0) begin
				$error("unexpected result beat: kind %0d status %0d id %h last %0d",
					result.result_kind, result.status_code, result.fired_id,
					result.last_of_run);
				fail_count++;
			end else begin
				want = owed_results.pop_front();
				if (result.result_kind !== want.result_kind) begin
					$error("result_kind expected %0d actual %0d", want.result_kind,
						result.result_kind);
					fail_count++;
				end
				if (result.status_code !== want.status_code) begin
					$error("status_code expected %0d actual %0d", want.status_code,
						result.status_code);
					fail_count++;
				end
				if (result.fired_id !== want.fired_id) begin
					$error("fired_id expected %h actual %h", want.fired_id, result.fired_id);
					fail_count++;
				end
				if (result.last_of_run !== want.last_of_run) begin
					$error("last_of_run expected %0d actual %0d", want.last_of_run,
						result.last_of_run);
					fail_count++;
				end
			end
		end
	end

	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((start && !busy) || strobe) idle_cycles = 0;
			else idle_cycles++;
		end
		$display("status: fail");
		$finish;
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		test_empty_bank();
		test_full_bank();
		test_random_traffic();
		start <= 1'b0;
		while (owed_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) $display("status: pass");
		else $display("status: fail");
		$finish;
	end

endmodule
